// File: rtl/lsdp_pkg.sv
// Shared constants, controller state type and control structs for the LRU profiler.
`timescale 1ns / 1ps

package lsdp_pkg;

  // default sizes
  localparam int StackDepthDef = 64;
  localparam int AddrBitsDef   = 48;
  localparam int CountBitsDef  = 32;

  // fixed result field widths
  localparam int DistW = 6;
  localparam int SizeW = 7;
  localparam int HitsW = 38;

  // input action codes
  localparam logic ActAccess = 1'b0;
  localparam logic ActDump   = 1'b1;

  // result kinds
  localparam logic KindAccess = 1'b0;
  localparam logic KindCurve  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ENC,
    ST_RD,
    ST_COMMIT,
    ST_DRD,
    ST_DEMIT,
    ST_DEMPTY
  } state_t;

  typedef struct packed {
    logic accept;      // latch word, compare against stack
    logic clear_wr;    // write zero to bin at idx
    logic inc_idx;     // advance bin index
    logic clr_idx;     // restart bin index
    logic enc;         // encode match vector
    logic rd_hist;     // read bin at hit distance
    logic rd_dump;     // read bin at idx
    logic commit;      // update stack/bin, load access report
    logic emit_dump;   // accumulate and load curve entry
    logic emit_empty;  // load the empty-stack curve entry
  } dp_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic idx_last_clear;
    logic idx_last_dump;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/lru_stack_distance_profiler_unit.sv
// Top level of the LRU stack-distance profiler: controller plus datapath.
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | in        | in_valid / in_ready | action, page_address
//  out     | out       | out_valid/out_ready | result_kind, was_hit, stack_distance,
//          |           |                     | cache_size, hits_at_size, last
//
// Access: accept+compare, encode, bin read, then commit loads the result.
// Dump: accept, then a bin read and an accumulate step per curve entry;
// an empty dump emits a single curve entry.
// One word in flight; in_ready is high whenever the controller is idle, even if
// the result register still holds an untaken word.
// Reset: a clearing pass zeroes the histogram, in_ready low.
// A full result register stalls the commit/emit step until out_ready.

module lru_stack_distance_profiler_unit #(
  parameter int STACK_DEPTH = lsdp_pkg::StackDepthDef,
  parameter int ADDR_BITS   = lsdp_pkg::AddrBitsDef,
  parameter int COUNT_BITS  = lsdp_pkg::CountBitsDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic [ADDR_BITS-1:0]       page_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       result_kind,
  output logic                       was_hit,
  output logic [lsdp_pkg::DistW-1:0] stack_distance,
  output logic [lsdp_pkg::SizeW-1:0] cache_size,
  output logic [lsdp_pkg::HitsW-1:0] hits_at_size,
  output logic                       last
);

  lsdp_pkg::dp_cmd_t cmd;
  lsdp_pkg::dp_sts_t sts;

  // sequencing: clear pass, access and dump flows
  lsdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stack cells, histogram memory and result register
  lsdp_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .page_address   (page_address),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .result_kind    (result_kind),
    .was_hit        (was_hit),
    .stack_distance (stack_distance),
    .cache_size     (cache_size),
    .hits_at_size   (hits_at_size),
    .last           (last)
  );

endmodule

// File: rtl/lsdp_ctrl.sv
// Controller state machine for the LRU profiler.
`timescale 1ns / 1ps

module lsdp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               action,
  output logic               in_ready,
  input  lsdp_pkg::dp_sts_t  sts,
  output lsdp_pkg::dp_cmd_t  cmd
);

  lsdp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsdp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      lsdp_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.idx_last_clear) begin
          cmd.clr_idx = 1'b1;
          state_next  = lsdp_pkg::ST_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      lsdp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (action == lsdp_pkg::ActDump) begin
            state_next = sts.fill_zero ? lsdp_pkg::ST_DEMPTY : lsdp_pkg::ST_DRD;
          end else begin
            state_next = lsdp_pkg::ST_ENC;
          end
        end
      end
      lsdp_pkg::ST_ENC: begin
        cmd.enc    = 1'b1;
        state_next = lsdp_pkg::ST_RD;
      end
      lsdp_pkg::ST_RD: begin
        cmd.rd_hist = 1'b1;
        state_next  = lsdp_pkg::ST_COMMIT;
      end
      lsdp_pkg::ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = lsdp_pkg::ST_IDLE;
        end
      end
      lsdp_pkg::ST_DRD: begin
        cmd.rd_dump = 1'b1;
        state_next  = lsdp_pkg::ST_DEMIT;
      end
      lsdp_pkg::ST_DEMIT: begin
        if (sts.out_free) begin
          cmd.emit_dump = 1'b1;
          if (sts.idx_last_dump) begin
            state_next = lsdp_pkg::ST_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = lsdp_pkg::ST_DRD;
          end
        end
      end
      lsdp_pkg::ST_DEMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = lsdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lsdp_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/lsdp_datapath.sv
// Datapath: recency stack cells, histogram memory, curve accumulator, result register.
`timescale 1ns / 1ps

module lsdp_datapath #(
  parameter int STACK_DEPTH = lsdp_pkg::StackDepthDef,
  parameter int ADDR_BITS   = lsdp_pkg::AddrBitsDef,
  parameter int COUNT_BITS  = lsdp_pkg::CountBitsDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ADDR_BITS-1:0]       page_address,
  input  lsdp_pkg::dp_cmd_t          cmd,
  output lsdp_pkg::dp_sts_t          sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       result_kind,
  output logic                       was_hit,
  output logic [lsdp_pkg::DistW-1:0] stack_distance,
  output logic [lsdp_pkg::SizeW-1:0] cache_size,
  output logic [lsdp_pkg::HitsW-1:0] hits_at_size,
  output logic                       last
);

  localparam int IdxW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FillW = $clog2(STACK_DEPTH + 1);
  localparam int SumW  = ((COUNT_BITS > lsdp_pkg::HitsW) ? COUNT_BITS : lsdp_pkg::HitsW) + 1;
  localparam logic [SumW-1:0]  HitsMax = {{(SumW - lsdp_pkg::HitsW){1'b0}},
                                          {lsdp_pkg::HitsW{1'b1}}};
  localparam logic [IdxW-1:0]  IdxLast = IdxW'(STACK_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(STACK_DEPTH);

  // recency stack, entry 0 is most recent
  logic [ADDR_BITS-1:0]  stack [STACK_DEPTH];
  logic [FillW-1:0]      fill;
  logic [ADDR_BITS-1:0]  addr;
  logic [STACK_DEPTH-1:0] match;
  logic                  hit;
  logic [IdxW-1:0]       hit_depth;
  logic [IdxW-1:0]       lim;
  logic [IdxW-1:0]       idx;
  logic [lsdp_pkg::HitsW-1:0] sum;

  // histogram memory
  logic [COUNT_BITS-1:0] hist_mem [STACK_DEPTH];
  logic [COUNT_BITS-1:0] rd_data;
  logic [IdxW-1:0]       rd_addr;
  logic                  rd_en;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  logic                  enc_hit;
  logic [IdxW-1:0]       enc_dist;
  logic [COUNT_BITS-1:0] bin_inc;
  logic [SumW-1:0]       sum_add;
  logic [lsdp_pkg::HitsW-1:0] sum_sat;
  logic [FillW-1:0]      size_cnt;
  logic [IdxW+lsdp_pkg::DistW-1:0]  dist_ext;
  logic [FillW+lsdp_pkg::SizeW-1:0] size_ext;
  logic                  out_load;

  // one-hot match to index; entries are distinct so at most one bit is set
  always_comb begin
    enc_hit  = |match;
    enc_dist = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      enc_dist = enc_dist | (match[i] ? IdxW'(i) : '0);
    end
  end

  assign bin_inc  = (&rd_data) ? rd_data : rd_data + 1'b1;
  assign sum_add  = SumW'(sum) + SumW'(rd_data);
  assign sum_sat  = (sum_add > HitsMax) ? {lsdp_pkg::HitsW{1'b1}}
                                        : sum_add[lsdp_pkg::HitsW-1:0];
  assign size_cnt = FillW'(idx) + 1'b1;
  assign dist_ext = {{lsdp_pkg::DistW{1'b0}}, hit_depth};
  assign size_ext = {{lsdp_pkg::SizeW{1'b0}}, size_cnt};

  assign rd_en   = cmd.rd_hist | cmd.rd_dump;
  assign rd_addr = cmd.rd_dump ? idx : hit_depth;
  assign wr_en   = cmd.clear_wr | (cmd.commit & hit);
  assign wr_addr = cmd.clear_wr ? idx : hit_depth;
  assign wr_data = cmd.clear_wr ? '0 : bin_inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= hist_mem[rd_addr];
    end
  end

  // parallel compare against the incoming word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr <= page_address;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        match[i] <= (FillW'(i) < fill) && (stack[i] == page_address);
      end
    end
    if (cmd.enc) begin
      hit       <= enc_hit;
      hit_depth <= enc_dist;
      lim       <= enc_hit ? enc_dist : IdxLast;
    end
  end

  // move-to-front / push: cells up to the limit take their upper neighbor
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        if (IdxW'(i) <= lim) begin
          stack[i] <= (i == 0) ? addr : stack[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      idx  <= '0;
    end else begin
      if (cmd.commit && !hit && fill != FillMax) begin
        fill <= fill + 1'b1;
      end
      if (cmd.accept || cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum <= '0;
    end else if (cmd.emit_dump) begin
      sum <= sum_sat;
    end
  end

  // result register
  assign out_load = cmd.commit | cmd.emit_dump | cmd.emit_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind    <= cmd.commit ? lsdp_pkg::KindAccess : lsdp_pkg::KindCurve;
      was_hit        <= cmd.commit & hit;
      stack_distance <= (cmd.commit && hit) ? dist_ext[lsdp_pkg::DistW-1:0] : '0;
      cache_size     <= cmd.emit_dump ? size_ext[lsdp_pkg::SizeW-1:0] : '0;
      hits_at_size   <= cmd.emit_dump ? sum_sat : '0;
      last           <= cmd.emit_dump ? sts.idx_last_dump : 1'b1;
    end
  end

  assign sts.fill_zero      = (fill == '0);
  assign sts.idx_last_clear = (idx == IdxLast);
  assign sts.idx_last_dump  = (size_cnt == fill);
  assign sts.out_free       = ~out_valid | out_ready;

endmodule
